### design/constant_accel_track_update_top_macros.svh
// Assertion macros for the constant-acceleration track update block.
// Used by the top level; no dependencies.
`ifndef CONSTANT_ACCEL_TRACK_UPDATE_TOP_MACROS_SVH
`define CONSTANT_ACCEL_TRACK_UPDATE_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define CATU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CATU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/catu_pkg.sv
// Package for the track update block: widths, stage depth, register indexes, status codes and beat types.
// No dependencies.
package catu_pkg;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned SqrtBits = 35;  // root bits 34..0
  localparam int unsigned DivBits = 21;   // quotient bits 20..0
  // pipeline depth: 3 front + 35 root + 1 product + 21 divide + 1 final
  localparam int unsigned PipeDepth = 3 + SqrtBits + 1 + DivBits + 1;

  typedef enum logic [1:0] {
    RegStartX = 2'd0,
    RegStartY = 2'd1,
    RegStartZ = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StOk = 2'd0,
    StCosUndef = 2'd1,
    StSat = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [23:0] vel_z;
    logic signed [19:0] acc_x;
    logic signed [19:0] acc_y;
    logic signed [19:0] acc_z;
    logic [23:0] time_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [23:0] speed;
    logic [31:0] travelled;
    logic [31:0] range_from_origin;
    logic signed [15:0] angle_cosine;
    logic [1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] index;
    logic [31:0] data;
  } cfg_beat_t;

  // one axis as produced by a lane
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [32:0] delta;  // saturated pos minus start
    logic signed [28:0] vn;     // updated velocity, full width
    logic sat;
  } lane_res_t;

  // common squaring-root step record
  typedef struct packed {
    logic [69:0] rad;
    logic [34:0] root;
  } sqrt_st_t;
endpackage

### design/catu_if.sv
// Valid/ready stream interface used for all channels of the track update block.
// Depends on nothing; payload type given as parameter.
interface catu_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/catu_lane.sv
// One axis of the kinematic update: products, rounding and saturation.
// Depends on catu_pkg. Two register stages.
module catu_lane
  import catu_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [31:0] p0_i,
  input  logic signed [23:0] vel_i,
  input  logic signed [19:0] acc_i,
  input  logic [23:0] dt_i,
  input  logic [30:0] h_i,
  output lane_res_t res_o
);
  logic signed [48:0] vdt_q;
  logic signed [51:0] ah_q;
  logic signed [44:0] adt_q;
  logic signed [31:0] p0_q;
  logic signed [23:0] vel_q;
  logic signed [35:0] sum;
  logic signed [32:0] vdt_r;
  logic signed [35:0] ah_r;
  logic signed [28:0] adt_r;
  logic signed [31:0] pos;
  logic sat;

  // stage 1: the three products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vdt_q <= vel_i * $signed({1'b0, dt_i});
      ah_q <= acc_i * $signed({1'b0, h_i});
      adt_q <= acc_i * $signed({1'b0, dt_i});
      p0_q <= p0_i;
      vel_q <= vel_i;
    end
  end

  // round to Q.8, ties upward, then saturate
  always_comb begin
    vdt_r = 33'((vdt_q + 49'sd32768) >>> 16);
    ah_r = 36'((ah_q + 52'sd32768) >>> 16);
    adt_r = 29'((adt_q + 45'sd32768) >>> 16);
    sum = 36'(p0_q) + 36'(vdt_r) + ah_r;
    sat = (sum > 36'sd2147483647) || (sum < -36'sd2147483648);
    if (sum > 36'sd2147483647) begin
      pos = 32'sh7fffffff;
    end else if (sum < -36'sd2147483648) begin
      pos = 32'sh80000000;
    end else begin
      pos = sum[31:0];
    end
  end

  // stage 2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.pos <= pos;
      res_o.delta <= 33'(pos) - 33'(p0_q);
      res_o.vn <= 29'(vel_q) + adt_r;
      res_o.sat <= sat;
    end
  end
endmodule

### design/catu_sqrt.sv
// Pipelined integer square root, one result bit per stage (35 stages).
// Depends on catu_pkg.
module catu_sqrt
  import catu_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  logic [69:0] rad_i,
  output logic [34:0] root_o
);
  sqrt_st_t st_q [SqrtBits];
  sqrt_st_t st_in [SqrtBits];
  sqrt_st_t st_out [SqrtBits];

  for (genvar g = 0; g < SqrtBits; g++) begin : g_stage
    localparam int unsigned Bit = SqrtBits - 1 - g;
    logic [69:0] trial;
    if (g == 0) begin : g_first
      assign st_in[g] = '{rad: rad_i, root: '0};
    end else begin : g_next
      assign st_in[g] = st_q[g-1];
    end
    // trial bit: rad holds what is left of the radicand after root squared;
    // adding the bit costs root * 2^(Bit+1) + 2^(2*Bit)
    always_comb begin
      trial = (70'(st_in[g].root) << (Bit + 1)) | (70'd1 << (2 * Bit));
      st_out[g] = st_in[g];
      if (trial <= st_in[g].rad) begin
        st_out[g].rad = st_in[g].rad - trial;
        st_out[g].root = st_in[g].root | (35'd1 << Bit);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= st_out[g];
      end
    end
  end

  assign root_o = st_q[SqrtBits-1].root;
endmodule

### design/catu_merge.sv
// Merging stage: magnitudes, cosine by restoring division, status.
// Depends on catu_pkg and catu_sqrt.
module catu_merge
  import catu_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  lane_res_t lane_i [NumAxes],
  output out_beat_t res_o
);
  localparam int unsigned Lag = SqrtBits + 1 + DivBits;

  logic [69:0] rad_t, rad_r, rad_s;
  logic [32:0] abs_t [NumAxes];
  logic [31:0] abs_r [NumAxes];
  logic [28:0] abs_s [NumAxes];
  logic [65:0] sq_t [NumAxes];
  logic [63:0] sq_r [NumAxes];
  logic [57:0] sq_s [NumAxes];
  logic signed [60:0] prod [NumAxes];
  logic signed [61:0] dot_c;
  logic [34:0] trav_rt, rng_rt, spd_rt;
  logic signed [31:0] pos_d [NumAxes][Lag];
  logic sat_d [Lag];
  logic signed [61:0] dot_d [SqrtBits];
  logic [31:0] trav_w, rng_w;
  logic sat1;

  // squares and dot product of the lane results
  always_comb begin
    dot_c = '0;
    rad_t = '0;
    rad_r = '0;
    rad_s = '0;
    for (int i = 0; i < NumAxes; i++) begin
      abs_t[i] = (lane_i[i].delta < 0) ? 33'(-lane_i[i].delta) : 33'(lane_i[i].delta);
      abs_r[i] = (lane_i[i].pos < 0) ? 32'(-lane_i[i].pos) : 32'(lane_i[i].pos);
      abs_s[i] = (lane_i[i].vn < 0) ? 29'(-lane_i[i].vn) : 29'(lane_i[i].vn);
      sq_t[i] = abs_t[i] * abs_t[i];
      sq_r[i] = abs_r[i] * abs_r[i];
      sq_s[i] = abs_s[i] * abs_s[i];
      prod[i] = lane_i[i].pos * lane_i[i].vn;
      rad_t = rad_t + 70'(sq_t[i]);
      rad_r = rad_r + 70'(sq_r[i]);
      rad_s = rad_s + 70'(sq_s[i]);
      dot_c = dot_c + 62'(prod[i]);
    end
  end

  // three roots in parallel
  catu_sqrt u_sqrt_trav (.clk_i, .en_i, .rad_i(rad_t), .root_o(trav_rt));
  catu_sqrt u_sqrt_rng (.clk_i, .en_i, .rad_i(rad_r), .root_o(rng_rt));
  catu_sqrt u_sqrt_spd (.clk_i, .en_i, .rad_i(rad_s), .root_o(spd_rt));

  // delay lines alongside the roots and the divider
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < Lag; k++) begin
        for (int i = 0; i < NumAxes; i++) begin
          pos_d[i][k] <= (k == 0) ? lane_i[i].pos : pos_d[i][k-1];
        end
        sat_d[k] <= (k == 0) ? (lane_i[0].sat | lane_i[1].sat | lane_i[2].sat)
                             : sat_d[k-1];
      end
      for (int k = 0; k < SqrtBits; k++) begin
        dot_d[k] <= (k == 0) ? dot_c : dot_d[k-1];
      end
    end
  end

  // product stage: saturate magnitudes, build numerator and divisor
  logic [60:0] den;
  logic [61:0] dot_abs;
  logic [77:0] num;
  logic dot_neg;
  logic undef;
  always_comb begin
    dot_neg = dot_d[SqrtBits-1] < 0;
    dot_abs = dot_neg ? 62'(-dot_d[SqrtBits-1]) : 62'(dot_d[SqrtBits-1]);
    sat1 = sat_d[SqrtBits-1] | (trav_rt > 35'h0ffffffff) | (rng_rt > 35'h0ffffffff);
    trav_w = (trav_rt > 35'h0ffffffff) ? 32'hffffffff : trav_rt[31:0];
    rng_w = (rng_rt > 35'h0ffffffff) ? 32'hffffffff : rng_rt[31:0];
    // speed is below 2^29, the unsaturated value enters the divisor
    den = rng_w * spd_rt[28:0];
    undef = (rng_w == '0) || (spd_rt == '0);
    num = {dot_abs, 16'd0} + 78'(den);
  end

  typedef struct packed {
    logic [77:0] rem;
    logic [61:0] den2;
    logic [20:0] q;
    logic neg;
    logic undef;
    logic sat;
    logic [31:0] trav;
    logic [31:0] rng;
    logic [23:0] spd;
  } div_st_t;

  div_st_t dv_q [DivBits+1];
  div_st_t dv_o [DivBits];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0].rem <= num;
      dv_q[0].den2 <= {den, 1'b0};
      dv_q[0].q <= '0;
      dv_q[0].neg <= dot_neg;
      dv_q[0].undef <= undef;
      dv_q[0].sat <= sat1 | (spd_rt > 35'hffffff);
      dv_q[0].trav <= trav_w;
      dv_q[0].rng <= rng_w;
      dv_q[0].spd <= (spd_rt > 35'hffffff) ? 24'hffffff : spd_rt[23:0];
    end
  end

  // restoring divide, one quotient bit per stage; rem is what is left
  for (genvar g = 0; g < DivBits; g++) begin : g_div
    localparam int unsigned Bit = DivBits - 1 - g;
    logic [81:0] trial;
    always_comb begin
      trial = 82'(dv_q[g].den2) << Bit;
      dv_o[g] = dv_q[g];
      if (trial <= 82'(dv_q[g].rem)) begin
        dv_o[g].rem = dv_q[g].rem - trial[77:0];
        dv_o[g].q = dv_q[g].q | (21'd1 << Bit);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[g+1] <= dv_o[g];
      end
    end
  end

  // final clamp and status
  div_st_t f;
  logic signed [15:0] cosv;
  logic [1:0] st;
  always_comb begin
    f = dv_q[DivBits];
    if (f.undef) begin
      cosv = '0;
      st = StCosUndef;
    end else begin
      if (!f.neg) begin
        cosv = (f.q > 21'd32767) ? 16'sd32767 : f.q[15:0];
      end else begin
        cosv = (f.q > 21'd32768) ? 16'sh8000 : 16'(-f.q[15:0]);
      end
      st = f.sat ? StSat : StOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.pos_x <= pos_d[0][Lag-1];
      res_o.pos_y <= pos_d[1][Lag-1];
      res_o.pos_z <= pos_d[2][Lag-1];
      res_o.speed <= f.spd;
      res_o.travelled <= f.trav;
      res_o.range_from_origin <= f.rng;
      res_o.angle_cosine <= cosv;
      res_o.status <= st;
    end
  end
endmodule

### design/constant_accel_track_update_top.sv
// Top level of the constant-acceleration track update block.
// Depends on catu_pkg, catu_if, catu_lane, catu_merge and the macros header.
// One item per clock while the output is taken: an input register, three axis
// lanes and a merging pipeline with three bit-per-stage square roots and a
// bit-per-stage divider. The pipeline stalls as a whole while the output beat
// is not taken. No clearing pass after reset.
`include "constant_accel_track_update_top_macros.svh"
module constant_accel_track_update_top
  import catu_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  catu_if.sink in_if,
  catu_if.sink cfg_if,
  catu_if.source out_if
);
  logic signed [31:0] start_q [NumAxes];
  logic [PipeDepth-1:0] vld_q;
  logic en;
  logic [30:0] h_d, h_q;
  in_beat_t in_q;
  in_beat_t in_b;
  lane_res_t lane [NumAxes];
  logic signed [23:0] vel [NumAxes];
  logic signed [19:0] acc [NumAxes];

  // whole pipe advances unless a finished beat is stuck at the output
  assign en = !(vld_q[PipeDepth-1] && !out_if.ready);
  assign in_if.ready = en;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_if.valid};
    end
  end

  // start position registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumAxes; i++) start_q[i] <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.data.index)
        RegStartX: start_q[0] <= cfg_if.data.data;
        RegStartY: start_q[1] <= cfg_if.data.data;
        RegStartZ: start_q[2] <= cfg_if.data.data;
        default: ;
      endcase
    end
  end

  // input register with half dt squared, ahead of the lane products
  assign h_d = 31'((48'(in_if.data.time_step) * 48'(in_if.data.time_step)) >> 17);
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_if.data;
      h_q <= h_d;
    end
  end

  assign in_b = in_q;
  assign vel[0] = in_b.vel_x;
  assign vel[1] = in_b.vel_y;
  assign vel[2] = in_b.vel_z;
  assign acc[0] = in_b.acc_x;
  assign acc[1] = in_b.acc_y;
  assign acc[2] = in_b.acc_z;

  for (genvar g = 0; g < NumAxes; g++) begin : g_lane
    catu_lane u_lane (
      .clk_i, .en_i(en), .p0_i(start_q[g]), .vel_i(vel[g]), .acc_i(acc[g]),
      .dt_i(in_b.time_step), .h_i(h_q), .res_o(lane[g])
    );
  end

  catu_merge u_merge (.clk_i, .en_i(en), .lane_i(lane), .res_o(out_if.data));

  `CATU_ASSERT_NXT(a_stall_hold, out_if.valid && !out_if.ready, out_if.valid, "output beat dropped")
  `CATU_ASSERT_IMP(a_undef_cos, out_if.valid && out_if.data.status == StCosUndef, out_if.data.angle_cosine == 16'sd0, "undefined cosine not zero")
  `CATU_ASSERT_IMP(a_status_rng, out_if.valid, out_if.data.status != 2'd3, "bad status code")
endmodule
